### rtl/pfa_pkg.sv
// Shared types and constants for the page frame allocator and table walker.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package pfa_pkg;

    // Operation codes carried in the op field.
    localparam logic [2:0] OP_ALLOC  = 3'd0;
    localparam logic [2:0] OP_FREE   = 3'd1;
    localparam logic [2:0] OP_INCREF = 3'd2;
    localparam logic [2:0] OP_DECREF = 3'd3;
    localparam logic [2:0] OP_LOOKUP = 3'd4;

    // Result status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_ABSENT    = 2'd1;
    localparam logic [1:0] ST_NO_FRAMES = 2'd2;
    localparam logic [1:0] ST_BAD       = 2'd3;

    // Walk levels: root, two intermediate tables, last one names the leaf table.
    localparam logic [1:0] LEVEL_ROOT = 2'd0;
    localparam logic [1:0] LEVEL_MID  = 2'd1;
    localparam logic [1:0] LEVEL_LAST = 2'd2;

    localparam int unsigned PAGE_OFFSET_BITS  = 12;
    localparam int unsigned ENTRIES_PER_TABLE = 512;
    localparam int unsigned INDEX_BITS        = 9;
    localparam logic [8:0]  INDEX_MAX         = 9'h1FF;
    localparam logic [1:0]  ENTRY_FLAGS       = 2'b11;  // write | present
    localparam logic [15:0] REF_MAX           = 16'hFFFF;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DISPATCH,
        S_ALLOC_RD,
        S_ALLOC_TAKE,
        S_REF_RD,
        S_REF_UPD,
        S_ENT_RD,
        S_ENT_CHECK,
        S_NEW_RD,
        S_NEW_TAKE,
        S_ZERO,
        S_LINK,
        S_DONE
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       init_step;
        logic       pop_rd;
        logic       pop_take;
        logic       push;
        logic       ref_rd;
        logic       ref_inc;
        logic       ref_dec;
        logic       ent_rd;
        logic       ent_take;
        logic       zero_step;
        logic       link;
        logic       level_inc;
        logic       set_pend;
        logic [1:0] pend_status;
        logic       pend_gnt;
        logic       pend_pte;
        logic       publish;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [2:0] op;
        logic       create;
        logic       init_last;
        logic       zero_last;
        logic       count_empty;
        logic       count_full;
        logic       fi_bad;
        logic       ref_zero;
        logic       ref_one;
        logic       ent_present;
        logic       ent_bad;
        logic       level_last;
        logic       out_free;
    } dp_status_t;

endpackage

### rtl/pfa_ctrl.sv
// Controller state machine for the page frame allocator and table walker.
// Depends on pfa_pkg; drives the datapath through dp_cmd_t only.
`timescale 1ns / 1ps

module pfa_ctrl
    import pfa_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  dp_status_t stat,
    output dp_cmd_t    cmd,
    output logic       s_tready
);

    ctrl_state_t state_reg, state_next;
    logic        s_tready_int;

    assign s_tready_int = (state_reg == S_IDLE);
    assign s_tready     = s_tready_int;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT: begin
                if (stat.init_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                // A transaction on the input channel starts the work.
                if (s_tvalid && s_tready_int) state_next = S_DISPATCH;
            end
            S_DISPATCH: begin
                priority case (stat.op)
                    OP_ALLOC:  state_next = stat.count_empty ? S_DONE : S_ALLOC_RD;
                    OP_FREE:   state_next = S_DONE;
                    OP_INCREF,
                    OP_DECREF: state_next = stat.fi_bad ? S_DONE : S_REF_RD;
                    OP_LOOKUP: state_next = S_ENT_RD;
                    default:   state_next = S_DONE;
                endcase
            end
            S_ALLOC_RD:   state_next = S_ALLOC_TAKE;
            S_ALLOC_TAKE: state_next = S_DONE;
            S_REF_RD:     state_next = S_REF_UPD;
            S_REF_UPD:    state_next = S_DONE;
            S_ENT_RD:     state_next = S_ENT_CHECK;
            S_ENT_CHECK: begin
                if (stat.ent_present) begin
                    state_next = (stat.ent_bad || stat.level_last) ? S_DONE : S_ENT_RD;
                end else if (!stat.create || stat.count_empty) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_NEW_RD;
                end
            end
            S_NEW_RD:   state_next = S_NEW_TAKE;
            S_NEW_TAKE: state_next = S_ZERO;
            S_ZERO: begin
                if (stat.zero_last) state_next = S_LINK;
            end
            S_LINK: state_next = stat.level_last ? S_DONE : S_ENT_RD;
            S_DONE: begin
                if (stat.out_free) state_next = S_IDLE;
            end
            default: state_next = S_INIT;
        endcase
    end

    // Outputs.
    always_comb begin
        cmd = '0;
        unique case (state_reg)
            S_INIT: cmd.init_step = 1'b1;
            S_IDLE: cmd.load = 1'b1;
            S_DISPATCH: begin
                priority case (stat.op)
                    OP_ALLOC: begin
                        if (stat.count_empty) begin
                            cmd.set_pend    = 1'b1;
                            cmd.pend_status = ST_NO_FRAMES;
                        end
                    end
                    OP_FREE: begin
                        cmd.set_pend = 1'b1;
                        if (stat.fi_bad || stat.count_full) begin
                            cmd.pend_status = ST_BAD;
                        end else begin
                            cmd.push        = 1'b1;
                            cmd.pend_status = ST_OK;
                        end
                    end
                    OP_INCREF, OP_DECREF: begin
                        if (stat.fi_bad) begin
                            cmd.set_pend    = 1'b1;
                            cmd.pend_status = ST_BAD;
                        end
                    end
                    OP_LOOKUP: ;
                    default: begin
                        cmd.set_pend    = 1'b1;
                        cmd.pend_status = ST_BAD;
                    end
                endcase
            end
            S_ALLOC_RD: cmd.pop_rd = 1'b1;
            S_ALLOC_TAKE: begin
                cmd.pop_take    = 1'b1;
                cmd.set_pend    = 1'b1;
                cmd.pend_status = ST_OK;
                cmd.pend_gnt    = 1'b1;
            end
            S_REF_RD: cmd.ref_rd = 1'b1;
            S_REF_UPD: begin
                cmd.set_pend    = 1'b1;
                cmd.pend_status = ST_OK;
                if (stat.op == OP_INCREF) begin
                    cmd.ref_inc = 1'b1;
                end else if (stat.ref_zero) begin
                    cmd.pend_status = ST_BAD;
                end else begin
                    cmd.ref_dec = 1'b1;
                    // The count reaches zero: the frame goes back on the stack unless it is full.
                    if (stat.ref_one) begin
                        if (stat.count_full) cmd.pend_status = ST_BAD;
                        else                 cmd.push        = 1'b1;
                    end
                end
            end
            S_ENT_RD: cmd.ent_rd = 1'b1;
            S_ENT_CHECK: begin
                if (stat.ent_present) begin
                    if (stat.ent_bad) begin
                        cmd.set_pend    = 1'b1;
                        cmd.pend_status = ST_BAD;
                    end else begin
                        cmd.ent_take = 1'b1;
                        if (stat.level_last) begin
                            cmd.set_pend    = 1'b1;
                            cmd.pend_status = ST_OK;
                            cmd.pend_pte    = 1'b1;
                        end else begin
                            cmd.level_inc = 1'b1;
                        end
                    end
                end else if (!stat.create) begin
                    cmd.set_pend    = 1'b1;
                    cmd.pend_status = ST_ABSENT;
                end else if (stat.count_empty) begin
                    cmd.set_pend    = 1'b1;
                    cmd.pend_status = ST_NO_FRAMES;
                end
            end
            S_NEW_RD:   cmd.pop_rd    = 1'b1;
            S_NEW_TAKE: cmd.pop_take  = 1'b1;
            S_ZERO:     cmd.zero_step = 1'b1;
            S_LINK: begin
                cmd.link = 1'b1;
                if (stat.level_last) begin
                    cmd.set_pend    = 1'b1;
                    cmd.pend_status = ST_OK;
                    cmd.pend_pte    = 1'b1;
                end else begin
                    cmd.level_inc = 1'b1;
                end
            end
            S_DONE: cmd.publish = stat.out_free;
            default: ;
        endcase
    end

endmodule

### rtl/pfa_datapath.sv
// Datapath: free stack, reference counts, root table, frame memory and result register.
// Depends on pfa_pkg; steered by the controller through dp_cmd_t.
`timescale 1ns / 1ps

module pfa_datapath
    import pfa_pkg::*;
#(
    parameter int NUM_FRAMES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  dp_cmd_t     cmd,
    output dp_status_t  stat,
    input  logic        in_fire,
    input  logic [2:0]  in_op,
    input  logic [3:0]  in_frame_index,
    input  logic [47:0] in_virt_addr,
    input  logic        in_create,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  out_status,
    output logic [3:0]  out_granted_frame,
    output logic [15:0] out_pte_address
);

    localparam int FW       = $clog2(NUM_FRAMES);
    localparam int CW       = $clog2(NUM_FRAMES + 1);
    localparam int INIT_LEN = (NUM_FRAMES > 512) ? NUM_FRAMES : 512;
    localparam int IW       = $clog2(INIT_LEN);
    localparam int FM_DEPTH = NUM_FRAMES * 512;

    // Captured request.
    logic [2:0]  op_reg;
    logic [3:0]  fi_reg;
    logic [47:0] va_reg;
    logic        create_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load && in_fire) begin
            op_reg     <= in_op;
            fi_reg     <= in_frame_index;
            va_reg     <= in_virt_addr;
            create_reg <= in_create;
        end
    end

    // Control registers.
    logic [IW-1:0] icnt_reg;
    logic [CW-1:0] count_reg;
    logic [8:0]    zcnt_reg;
    logic [1:0]    level_reg;
    logic [FW-1:0] cur_reg, par_reg;

    logic [FW-1:0] stack_rdata, fi_idx;
    logic [15:0]   ref_rdata;
    logic [63:0]   root_rdata, fm_rdata, ent;
    logic [8:0]    lvl_idx;

    assign fi_idx  = FW'(fi_reg);
    assign lvl_idx = (level_reg == LEVEL_MID) ? va_reg[38:30] : va_reg[29:21];
    assign ent     = (level_reg == LEVEL_ROOT) ? root_rdata : fm_rdata;

    // Walk and sweep counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            icnt_reg  <= '0;
            count_reg <= CW'(NUM_FRAMES);
            zcnt_reg  <= '0;
            level_reg <= LEVEL_ROOT;
        end else begin
            if (cmd.init_step) icnt_reg <= icnt_reg + 1'b1;
            if (cmd.pop_take)  count_reg <= count_reg - 1'b1;
            else if (cmd.push) count_reg <= count_reg + 1'b1;
            if (cmd.pop_take)       zcnt_reg <= '0;
            else if (cmd.zero_step) zcnt_reg <= zcnt_reg + 1'b1;
            if (cmd.load)           level_reg <= LEVEL_ROOT;
            else if (cmd.level_inc) level_reg <= level_reg + 1'b1;
        end
    end

    // Current and parent frames of the walk.
    always_ff @(posedge aclk) begin
        if (cmd.ent_rd)   par_reg <= cur_reg;
        if (cmd.pop_take) cur_reg <= stack_rdata;
        else if (cmd.ent_take) cur_reg <= ent[FW+PAGE_OFFSET_BITS-1:PAGE_OFFSET_BITS];
    end

    // Free stack memory.
    logic [FW-1:0] free_stack [NUM_FRAMES];
    logic [FW-1:0] count_m1;
    logic          init_frame;
    assign count_m1   = count_reg[FW-1:0] - 1'b1;
    assign init_frame = (32'(icnt_reg) < NUM_FRAMES);

    always_ff @(posedge aclk) begin
        if (cmd.init_step && init_frame) begin
            free_stack[icnt_reg[FW-1:0]] <= FW'(NUM_FRAMES - 1) - icnt_reg[FW-1:0];
        end else if (cmd.push) begin
            free_stack[count_reg[FW-1:0]] <= fi_idx;
        end
        stack_rdata <= free_stack[count_m1];
    end

    // Reference count memory.
    logic [15:0]   ref_counts [NUM_FRAMES];
    logic          ref_we;
    logic [FW-1:0] ref_wa;
    logic [15:0]   ref_wd;

    always_comb begin
        ref_we = 1'b1;
        ref_wa = fi_idx;
        ref_wd = ref_rdata - 1'b1;
        priority if (cmd.init_step) begin
            ref_we = init_frame;
            ref_wa = icnt_reg[FW-1:0];
            ref_wd = '0;
        end else if (cmd.link) begin
            ref_wa = cur_reg;
            ref_wd = 16'd1;
        end else if (cmd.ref_inc) begin
            ref_wd = (ref_rdata == REF_MAX) ? REF_MAX : ref_rdata + 1'b1;
        end else if (cmd.ref_dec) begin
            ref_wd = ref_rdata - 1'b1;
        end else begin
            ref_we = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ref_we) ref_counts[ref_wa] <= ref_wd;
        ref_rdata <= ref_counts[fi_idx];
    end

    // Root table memory, cleared by the sweep after reset.
    logic [63:0] root_table [ENTRIES_PER_TABLE];
    logic [63:0] link_entry;
    logic [FW+11:0] cur_pa;
    assign cur_pa     = {cur_reg, 12'b0};
    assign link_entry = {52'(cur_pa >> 12), 10'b0, ENTRY_FLAGS};

    always_ff @(posedge aclk) begin
        if (cmd.init_step && (32'(icnt_reg) < 512)) begin
            root_table[icnt_reg[8:0]] <= '0;
        end else if (cmd.link && level_reg == LEVEL_ROOT) begin
            root_table[va_reg[47:39]] <= link_entry;
        end
        root_rdata <= root_table[va_reg[47:39]];
    end

    // Frame memory: zeroed frame by frame as tables are created.
    logic [63:0]     frame_memory [FM_DEPTH];
    logic [FW+8:0]   fm_ra;
    assign fm_ra = {cur_reg, lvl_idx};

    always_ff @(posedge aclk) begin
        if (cmd.zero_step) begin
            frame_memory[{cur_reg, zcnt_reg}] <= '0;
        end else if (cmd.link && level_reg != LEVEL_ROOT) begin
            frame_memory[{par_reg, lvl_idx}] <= link_entry;
        end
        fm_rdata <= frame_memory[fm_ra];
    end

    // Pending result and output register.
    logic [1:0]  pend_status_reg;
    logic        pend_gnt_reg, pend_pte_reg;
    logic        res_valid_reg;
    logic [1:0]  res_status_reg;
    logic [3:0]  res_gnt_reg;
    logic [15:0] res_pte_reg;
    logic [FW+11:0] leaf_pa;
    assign leaf_pa = {cur_reg, va_reg[20:12], 3'b0};

    always_ff @(posedge aclk) begin
        if (cmd.set_pend) begin
            pend_status_reg <= cmd.pend_status;
            pend_gnt_reg    <= cmd.pend_gnt;
            pend_pte_reg    <= cmd.pend_pte;
        end
        if (cmd.publish) begin
            res_status_reg <= pend_status_reg;
            res_gnt_reg    <= pend_gnt_reg ? 4'(cur_reg) : 4'd0;
            res_pte_reg    <= pend_pte_reg ? 16'(leaf_pa) : 16'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (cmd.publish) begin
            res_valid_reg <= 1'b1;
        end else if (out_ready) begin
            res_valid_reg <= 1'b0;
        end
    end

    assign out_valid         = res_valid_reg;
    assign out_status        = res_status_reg;
    assign out_granted_frame = res_gnt_reg;
    assign out_pte_address   = res_pte_reg;

    // Status towards the controller.
    always_comb begin
        stat.op          = op_reg;
        stat.create      = create_reg;
        stat.init_last   = (icnt_reg == IW'(INIT_LEN - 1));
        stat.zero_last   = (zcnt_reg == INDEX_MAX);
        stat.count_empty = (count_reg == '0);
        stat.count_full  = (count_reg == CW'(NUM_FRAMES));
        stat.fi_bad      = (32'(fi_reg) >= NUM_FRAMES);
        stat.ref_zero    = (ref_rdata == 16'd0);
        stat.ref_one     = (ref_rdata == 16'd1);
        stat.ent_present = ent[0];
        stat.ent_bad     = (ent[51:PAGE_OFFSET_BITS] >= 40'(NUM_FRAMES));
        stat.level_last  = (level_reg == LEVEL_LAST);
        stat.out_free    = !res_valid_reg || out_ready;
    end

    // Checks on the stack bookkeeping and the result register.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) <= NUM_FRAMES)
        else $error("free count beyond pool size");
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop_rd |-> count_reg != '0)
        else $error("pop from empty free stack");
    a_push_notfull: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |-> count_reg != CW'(NUM_FRAMES))
        else $error("push onto full free stack");
    a_publish_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.publish |-> (!res_valid_reg || out_ready))
        else $error("result overwritten before transaction");

endmodule

### rtl/page_frame_allocator_table_walker_top.sv
// Top level of the page frame allocator and four-level table walker.
// Depends on pfa_pkg, pfa_ctrl and pfa_datapath.
//
// One input transaction on s_ carries a request; exactly one result transaction
// follows on m_. Requests are handled one at a time by the controller.
// A new table is zeroed one 64-bit entry per cycle through the single write
// port of the frame memory. After reset the block sweeps the root table, free
// stack and reference counts one entry a cycle and holds s_tready low
// meanwhile. A finished result waits in an output register; when the
// receiver stalls, the block accepts the next request and stops only
// when that request's result is ready while the previous is still untaken.
`timescale 1ns / 1ps

module page_frame_allocator_table_walker_top
    import pfa_pkg::*;
#(
    parameter int NUM_FRAMES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // op[2:0], frame_index[6:3], virt_addr[54:7], create[55]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // status[1:0], granted_frame[5:2], pte_address[21:6], zero
);

    dp_cmd_t    cmd;
    dp_status_t stat;
    logic       ready_int;
    logic       in_fire;
    logic [1:0]  out_status;
    logic [3:0]  out_granted;
    logic [15:0] out_pte;

    assign in_fire  = s_tvalid && ready_int;
    assign s_tready = ready_int;

    pfa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .stat     (stat),
        .cmd      (cmd),
        .s_tready (ready_int)
    );

    pfa_datapath #(
        .NUM_FRAMES (NUM_FRAMES)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .stat              (stat),
        .in_fire           (in_fire),
        .in_op             (s_tdata[2:0]),
        .in_frame_index    (s_tdata[6:3]),
        .in_virt_addr      (s_tdata[54:7]),
        .in_create         (s_tdata[55]),
        .out_valid         (m_tvalid),
        .out_ready         (m_tready),
        .out_status        (out_status),
        .out_granted_frame (out_granted),
        .out_pte_address   (out_pte)
    );

    assign m_tdata = {2'b00, out_pte, out_granted, out_status};

endmodule

### sim/page_frame_allocator_table_walker_top_tb.sv
// Self-checking testbench for page_frame_allocator_table_walker_top.
// Depends on pfa_pkg and the RTL of the block; reads no files.
`timescale 1ns / 1ps

module page_frame_allocator_table_walker_top_tb
    import pfa_pkg::*;
;

    localparam int FRAMES = 16;

    typedef struct {
        logic [1:0]  status;
        logic [3:0]  granted;
        logic [15:0] pte;
    } walk_result_t;

    typedef struct {
        logic [2:0]  op;
        logic [3:0]  fi;
        logic [47:0] va;
        logic        create;
        int          repeats;
        bit          typed;
        logic [1:0]  status;
        logic [3:0]  granted;
        logic [15:0] pte;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;   // op[2:0], frame_index[6:3], virt_addr[54:7], create[55]
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // status[1:0], granted_frame[5:2], pte_address[21:6], zero

    // Shadow copy of the pool and page tables.
    logic [3:0]   pool_stack [FRAMES];
    int           pool_free;
    logic [15:0]  refcnt [FRAMES];
    logic [63:0]  root_tbl [512];
    logic [63:0]  frame_mem [FRAMES*512];

    walk_result_t pending_results[$];
    stim_row_t    stim_rows[$];
    logic [47:0]  hot_va [6];

    bit failed;
    int gap_pct;
    int stall_pct;
    int hold_asks;
    int hold_done;
    int hold_left;

    page_frame_allocator_table_walker_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    initial begin
        #200ms;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic void clear_shadow();
        for (int i = 0; i < FRAMES; i++) begin
            pool_stack[i] = 4'(FRAMES - 1 - i);
            refcnt[i] = '0;
        end
        pool_free = FRAMES;
        foreach (root_tbl[i]) root_tbl[i] = '0;
        foreach (frame_mem[i]) frame_mem[i] = '0;
    endfunction

    function automatic bit pop_frame(output logic [3:0] f);
        if (pool_free == 0) return 1'b0;
        pool_free--;
        f = pool_stack[pool_free];
        return 1'b1;
    endfunction

    function automatic bit push_frame(input logic [3:0] f);
        if (pool_free >= FRAMES) return 1'b0;
        pool_stack[pool_free] = f;
        pool_free++;
        return 1'b1;
    endfunction

    // Applies one request to the shadow state and works out its result.
    function automatic walk_result_t walk_and_update(input logic [2:0] op,
                                                     input logic [3:0] fi,
                                                     input logic [47:0] va,
                                                     input logic create);
        walk_result_t r;
        logic [3:0]   f;
        logic [3:0]   nf;
        logic [63:0]  entry;
        logic [8:0]   idx;
        r = '{ST_OK, 4'd0, 16'd0};
        f = '0;
        case (op)
            OP_ALLOC: begin
                if (pop_frame(f)) r.granted = f;
                else r.status = ST_NO_FRAMES;
            end
            OP_FREE: begin
                if (!push_frame(fi)) r.status = ST_BAD;
            end
            OP_INCREF: begin
                if (refcnt[fi] != REF_MAX) refcnt[fi]++;
            end
            OP_DECREF: begin
                if (refcnt[fi] == 0) begin
                    r.status = ST_BAD;
                end else begin
                    refcnt[fi]--;
                    if (refcnt[fi] == 0 && !push_frame(fi)) r.status = ST_BAD;
                end
            end
            OP_LOOKUP: begin
                // Root, then two lower tables; the last names the leaf table.
                for (int lvl = 0; lvl < 3 && r.status == ST_OK; lvl++) begin
                    idx = va[47 - 9*lvl -: 9];
                    entry = (lvl == 0) ? root_tbl[idx] : frame_mem[{f, idx}];
                    if (!entry[0]) begin
                        if (!create) begin
                            r.status = ST_ABSENT;
                        end else if (!pop_frame(nf)) begin
                            r.status = ST_NO_FRAMES;
                        end else begin
                            for (int k = 0; k < 512; k++) frame_mem[{nf, 9'(k)}] = '0;
                            refcnt[nf] = 16'd1;
                            entry = (64'(nf) << 12) | 64'(ENTRY_FLAGS);
                            if (lvl == 0) root_tbl[idx] = entry;
                            else frame_mem[{f, idx}] = entry;
                        end
                    end
                    if (r.status == ST_OK) begin
                        if (entry[51:12] >= FRAMES) r.status = ST_BAD;
                        else f = entry[15:12];
                    end
                end
                if (r.status == ST_OK) r.pte = (16'(f) << 12) + 16'(va[20:12]) * 16'd8;
            end
            default: r.status = ST_BAD;
        endcase
        return r;
    endfunction

    // Offers one request and waits for its acceptance, then records the expectation.
    task automatic send_request(input stim_row_t row);
        walk_result_t r;
        s_tvalid <= 1'b1;
        s_tdata  <= {row.create, row.va, row.fi, row.op};
        do @(posedge aclk); while (!s_tready);
        r = walk_and_update(row.op, row.fi, row.va, row.create);
        if (row.typed) r = '{row.status, row.granted, row.pte};
        pending_results.push_back(r);
        if ($urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic add_row(input logic [2:0] op, input logic [3:0] fi, input logic [47:0] va,
                           input logic create, input int repeats, input bit typed,
                           input logic [1:0] st, input logic [3:0] gnt, input logic [15:0] pte);
        stim_rows.push_back('{op, fi, va, create, repeats, typed, st, gnt, pte});
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    function automatic stim_row_t random_row();
        stim_row_t row;
        int        pick;
        row = '{3'd0, 4'($urandom), 48'd0, 1'b0, 1, 1'b0, ST_OK, 4'd0, 16'd0};
        pick = $urandom_range(0, 99);
        if (pick < 12)      row.op = OP_ALLOC;
        else if (pick < 30) row.op = OP_FREE;
        else if (pick < 42) row.op = OP_INCREF;
        else if (pick < 54) row.op = OP_DECREF;
        else if (pick < 95) row.op = OP_LOOKUP;
        else                row.op = 3'($urandom_range(5, 7));
        // Mostly walk a few known addresses so that deep levels are reached.
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            row.va = hot_va[$urandom_range(0, 5)];
            row.va[20:0] = 21'($urandom);
        end else if (pick < 80) begin
            row.va = hot_va[$urandom_range(0, 5)];
            row.va[29:0] = 30'($urandom);
        end else begin
            row.va = {16'($urandom), 32'($urandom)};
        end
        row.create = ($urandom_range(0, 99) < 25);
        return row;
    endfunction

    // Result side: stalls, long hold-offs and checking.
    always @(posedge aclk) begin
        walk_result_t exp_r;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    $error("result transaction with nothing expected: %h", m_tdata);
                    failed = 1'b1;
                end else begin
                    exp_r = pending_results.pop_front();
                    if (m_tdata[1:0] !== exp_r.status) begin
                        $error("status: expected %0d, got %0d", exp_r.status, m_tdata[1:0]);
                        failed = 1'b1;
                    end
                    if (m_tdata[5:2] !== exp_r.granted) begin
                        $error("granted_frame: expected %0d, got %0d",
                               exp_r.granted, m_tdata[5:2]);
                        failed = 1'b1;
                    end
                    if (m_tdata[21:6] !== exp_r.pte) begin
                        $error("pte_address: expected %h, got %h", exp_r.pte, m_tdata[21:6]);
                        failed = 1'b1;
                    end
                end
            end
            if (hold_asks != hold_done) begin
                hold_done = hold_asks;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Stimulus: directed table first, then random phases with differing idle rates.
    initial begin
        stim_row_t row;
        int        guard;
        failed    = 1'b0;
        hold_asks = 0;
        hold_done = 0;
        hold_left = 0;
        gap_pct   = 0;
        stall_pct = 0;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        clear_shadow();
        for (int i = 0; i < 6; i++) hot_va[i] = {16'($urandom), 32'($urandom)};
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        add_row(OP_ALLOC,  4'd0,  48'd0, 1'b0, 1, 1'b1, ST_OK, 4'd0, 16'd0);
        add_row(OP_FREE,   4'd0,  48'd0, 1'b0, 1, 1'b1, ST_OK, 4'd0, 16'd0);
        // Stack is full again, so this push is refused.
        add_row(OP_FREE,   4'd5,  48'd0, 1'b0, 1, 1'b1, ST_BAD, 4'd0, 16'd0);
        add_row(OP_DECREF, 4'd3,  48'd0, 1'b0, 1, 1'b1, ST_BAD, 4'd0, 16'd0);
        add_row(OP_INCREF, 4'd15, 48'd0, 1'b0, 1, 1'b1, ST_OK, 4'd0, 16'd0);
        // Count drops to zero but the push onto a full stack is dropped.
        add_row(OP_DECREF, 4'd15, 48'd0, 1'b0, 1, 1'b1, ST_BAD, 4'd0, 16'd0);
        add_row(3'd5, 4'd0, 48'd0, 1'b0, 1, 1'b1, ST_BAD, 4'd0, 16'd0);
        add_row(3'd6, 4'd0, 48'd0, 1'b0, 1, 1'b1, ST_BAD, 4'd0, 16'd0);
        add_row(3'd7, 4'd15, 48'hFFFF_FFFF_FFFF, 1'b1, 1, 1'b1, ST_BAD, 4'd0, 16'd0);
        add_row(OP_LOOKUP, 4'd0, 48'd0, 1'b0, 1, 1'b1, ST_ABSENT, 4'd0, 16'd0);
        add_row(OP_LOOKUP, 4'd0, 48'd0, 1'b1, 1, 1'b0, ST_OK, 4'd0, 16'd0);
        add_row(OP_LOOKUP, 4'd0, 48'h0000_0000_1FF8, 1'b0, 1, 1'b0, ST_OK, 4'd0, 16'd0);
        add_row(OP_LOOKUP, 4'd0, 48'hFFFF_FFFF_FFFF, 1'b1, 1, 1'b0, ST_OK, 4'd0, 16'd0);
        add_row(OP_LOOKUP, 4'd0, 48'hFFFF_FFFF_FFFF, 1'b0, 1, 1'b0, ST_OK, 4'd0, 16'd0);
        // Root entry exists but the level below it does not.
        add_row(OP_LOOKUP, 4'd0, 48'h0000_4000_0000, 1'b0, 1, 1'b1, ST_ABSENT, 4'd0, 16'd0);
        // Raise one count several times and step back once.
        add_row(OP_INCREF, 4'd9, 48'd0, 1'b0, 20, 1'b0, ST_OK, 4'd0, 16'd0);
        add_row(OP_DECREF, 4'd9, 48'd0, 1'b0, 1, 1'b0, ST_OK, 4'd0, 16'd0);
        // Drain the pool; the last pop finds it empty.
        add_row(OP_ALLOC, 4'd0, 48'd0, 1'b0, 11, 1'b0, ST_OK, 4'd0, 16'd0);
        add_row(OP_LOOKUP, 4'd0, 48'h0080_0000_0000, 1'b1, 1, 1'b1,
                ST_NO_FRAMES, 4'd0, 16'd0);
        add_row(OP_FREE, 4'd12, 48'd0, 1'b0, 1, 1'b0, ST_OK, 4'd0, 16'd0);
        add_row(OP_FREE, 4'd13, 48'd0, 1'b0, 1, 1'b0, ST_OK, 4'd0, 16'd0);
        // Two levels are created before the pool runs dry again.
        add_row(OP_LOOKUP, 4'd0, 48'h0080_0000_0000, 1'b1, 1, 1'b0, ST_OK, 4'd0, 16'd0);
        add_row(OP_FREE, 4'd4, 48'd0, 1'b0, 4, 1'b0, ST_OK, 4'd0, 16'd0);
        add_row(OP_LOOKUP, 4'd0, 48'h0080_0000_0000, 1'b1, 1, 1'b0, ST_OK, 4'd0, 16'd0);

        foreach (stim_rows[i])
            repeat (stim_rows[i].repeats) send_request(stim_rows[i]);
        s_tvalid <= 1'b0;
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 46; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 46; end
                default: begin gap_pct = 18; stall_pct = 18; end
            endcase
            // The receiver holds off for a long stretch while requests keep coming.
            if (phase == 0 || phase == 3) hold_asks++;
            for (int n = 0; n < 375; n++) begin
                row = random_row();
                send_request(row);
            end
            s_tvalid <= 1'b0;
            wait_drained();
        end

        guard = 0;
        while (pending_results.size() != 0 && guard < 100000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (50) @(posedge aclk);
        if (!failed && pending_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/pfa_pkg.sv
rtl/pfa_ctrl.sv
rtl/pfa_datapath.sv
rtl/page_frame_allocator_table_walker_top.sv
sim/page_frame_allocator_table_walker_top_tb.sv
